[rtl/greedy_least_loaded_assigner_unit_defines.svh]
// ----------------------------------------------------------------------------
// greedy least-loaded assigner assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GREEDY_LEAST_LOADED_ASSIGNER_UNIT_DEFINES_SVH
`define GREEDY_LEAST_LOADED_ASSIGNER_UNIT_DEFINES_SVH

// same-cycle implication
`define GLLA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLLA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/glla_pkg.sv]
// ----------------------------------------------------------------------------
// glla_pkg
// types and constants shared by the least-loaded assigner cells and top level
// ----------------------------------------------------------------------------
`default_nettype none

package glla_pkg;

	localparam int LOAD_W      = 48;
	localparam int COUNT_W     = 11;
	localparam int COUNT_MAX   = 2047;
	localparam int PIDX_W      = 8;
	localparam int N_W         = 9;
	localparam int EXT_W       = 12;
	localparam int CFG_W       = 5;
	localparam int SLOT_W      = 10;
	localparam int PROC_OUT_W  = 4;
	localparam int DEF_NUM_PROCESSORS = 16;
	localparam int DEF_MAX_BLOCKS     = 1024;

	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	// search token walking down the cell chain
	typedef struct packed {
		logic               valid;
		logic               found;
		logic [PIDX_W-1:0]  idx;
		logic [LOAD_W-1:0]  load;
		logic [COUNT_W-1:0] count;
		logic [1:0]         zeros;
	} glla_tok_t;

	// update broadcast to the cells
	typedef struct packed {
		logic               en;
		logic [PIDX_W-1:0]  idx;
		logic [LOAD_W-1:0]  load;
		logic [COUNT_W-1:0] count;
	} glla_wr_t;

endpackage

`default_nettype wire

[rtl/greedy_least_loaded_assigner_unit.sv]
// ----------------------------------------------------------------------------
// greedy_least_loaded_assigner_unit
// list scheduler: each block goes to the least loaded active processor,
// ties to the lowest index; its extent product is added to that load
// ----------------------------------------------------------------------------
//  channel  signals                                  dir  accepted when
//  in       in_valid/in_stall, extents, first/last   in   in_valid && !in_stall
//  out      out_valid/out_stall, processor, slot     out  out_valid && !out_stall
//  cfg      cfg_we/cfg_wdata (active processors)     in   cfg_we
//
//  one item at a time: the next accept waits until the result fires, after the
//  token has walked the processor cell chain, one cell per cycle
//  reset clears all loads and counts, active processors comes up as 1
//  a stalled result holds the final update until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_least_loaded_assigner_unit_defines.svh"

module greedy_least_loaded_assigner_unit
	import glla_pkg::*;
#(
	parameter int NUM_PROCESSORS = DEF_NUM_PROCESSORS,
	parameter int MAX_BLOCKS     = DEF_MAX_BLOCKS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [EXT_W-1:0]      extent_i,
	input  wire logic [EXT_W-1:0]      extent_j,
	input  wire logic [EXT_W-1:0]      extent_k,
	input  wire logic                  first_block,
	input  wire logic                  last_block,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PROC_OUT_W-1:0]      assigned_processor,
	output logic [SLOT_W-1:0]          slot_in_processor,
	output logic                       empty_processor_flag,
	output logic                       load_saturated,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata
);

	localparam int CNT_CAP  = (MAX_BLOCKS > COUNT_MAX) ? COUNT_MAX : MAX_BLOCKS;
	localparam int SLOT_CAP = MAX_BLOCKS - 1;

	logic [CFG_W-1:0]     active_q;
	logic [N_W-1:0]       act_ext;
	logic [N_W-1:0]       n_eff;
	logic                 busy_q;
	logic                 accept;
	logic                 fire;
	logic [EXT_W-1:0]     ei_q;
	logic [EXT_W-1:0]     ej_q;
	logic [EXT_W-1:0]     ek_q;
	logic                 last_q;
	logic                 seed_q;
	logic [2*EXT_W-1:0]   prod_ij_s1;
	logic [3*EXT_W-1:0]   work_s2;
	glla_tok_t            tok [NUM_PROCESSORS+1];
	logic [NUM_PROCESSORS:0] tok_valid_vec;
	logic                 tail_valid_q;
	glla_tok_t            tail_q;
	logic [LOAD_W:0]      sum;
	logic [LOAD_W-1:0]    new_load;
	logic [COUNT_W-1:0]   new_count;
	logic [16:0]          count_ext;
	logic [16:0]          slot_full;
	logic                 empty;
	glla_wr_t             wr;
	logic                 out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(1);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	assign act_ext = N_W'(active_q);
	assign n_eff   = (act_ext == '0) ? N_W'(1) :
			(act_ext > N_W'(NUM_PROCESSORS)) ? N_W'(NUM_PROCESSORS) : act_ext;

	// input side
	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			ei_q   <= extent_i;
			ej_q   <= extent_j;
			ek_q   <= extent_k;
			last_q <= last_block;
		end
		prod_ij_s1 <= ei_q * ej_q;
		work_s2    <= prod_ij_s1 * (3*EXT_W)'(ek_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seed_q <= 1'b0;
		end else begin
			seed_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
		end
	end

	// processor cell chain
	assign tok[0] = '{valid: seed_q, default: '0};

	for (genvar p = 0; p < NUM_PROCESSORS; p++) begin : g_cell
		glla_cell #(
			.CELL_IDX(p)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (accept && first_block),
			.n_act  (n_eff),
			.tok_in (tok[p]),
			.wr     (wr),
			.tok_out(tok[p+1])
		);
	end

	always_comb begin
		for (int p = 0; p <= NUM_PROCESSORS; p++) begin
			tok_valid_vec[p] = tok[p].valid;
		end
	end

	// tail: load update and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_q <= 1'b0;
		end else if (tok[NUM_PROCESSORS].valid) begin
			tail_valid_q <= 1'b1;
		end else if (fire) begin
			tail_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[NUM_PROCESSORS].valid) begin
			tail_q <= tok[NUM_PROCESSORS];
		end
	end

	assign fire      = tail_valid_q && (!out_valid_q || !out_stall);
	assign sum       = {1'b0, tail_q.load} + (LOAD_W+1)'(work_s2);
	assign new_load  = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
	assign new_count = (tail_q.count < COUNT_W'(CNT_CAP)) ?
			tail_q.count + COUNT_W'(1) : tail_q.count;
	assign count_ext = 17'(tail_q.count);
	assign slot_full = (count_ext > 17'(SLOT_CAP)) ? 17'(SLOT_CAP) : count_ext;
	// best processor is never empty after its update
	assign empty     = last_q && (tail_q.zeros[1] ||
			((tail_q.zeros == 2'd1) && (tail_q.count != '0)));

	always_comb begin
		wr.en    = fire;
		wr.idx   = tail_q.idx;
		wr.load  = new_load;
		wr.count = new_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			assigned_processor   <= tail_q.idx[PROC_OUT_W-1:0];
			slot_in_processor    <= slot_full[SLOT_W-1:0];
			empty_processor_flag <= empty;
			load_saturated       <= (new_load == LOAD_MAX);
		end
	end

	assign out_valid = out_valid_q;

	`GLLA_ASSERT_NOW(a_single_token, 1'b1, $onehot0(tok_valid_vec), "more than one search token in chain")
	`GLLA_ASSERT_NOW(a_token_busy, tok_valid_vec != '0, busy_q, "search token without item in flight")
	`GLLA_ASSERT_NOW(a_pick_active, tail_valid_q, ({1'b0, tail_q.idx} < n_eff), "chosen processor not active")
	`GLLA_ASSERT_NEXT(a_fire_out, fire, out_valid, "result lost after update")

endmodule

`default_nettype wire

[rtl/glla_cell.sv]
// ----------------------------------------------------------------------------
// glla_cell
// holds one processor's load and block count, folds them into the passing
// search token and takes the update addressed to it
// ----------------------------------------------------------------------------
`default_nettype none

module glla_cell
	import glla_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      clr,
	input  wire logic [N_W-1:0] n_act,
	input  wire glla_tok_t tok_in,
	input  wire glla_wr_t  wr,
	output glla_tok_t      tok_out
);

	logic [LOAD_W-1:0]  load_q;
	logic [COUNT_W-1:0] count_q;
	glla_tok_t          tok_q;
	glla_tok_t          tok_d;
	logic               active;
	logic               take;

	assign active = N_W'(CELL_IDX) < n_act;
	assign take   = active && (!tok_in.found || (load_q < tok_in.load));

	always_comb begin
		tok_d = tok_in;
		if (tok_in.valid && take) begin
			tok_d.found = 1'b1;
			tok_d.idx   = PIDX_W'(CELL_IDX);
			tok_d.load  = load_q;
			tok_d.count = count_q;
		end
		if (tok_in.valid && active && (count_q == '0) && (tok_in.zeros != 2'b11)) begin
			tok_d.zeros = tok_in.zeros + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			count_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (clr) begin
				load_q  <= '0;
				count_q <= '0;
			end else if (wr.en && (wr.idx == PIDX_W'(CELL_IDX))) begin
				load_q  <= wr.load;
				count_q <= wr.count;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the least-loaded block assigner: a scoreboard keeps
// its own copy of every processor load and block count, predicts the chosen
// processor, slot, empty and saturation flags of each item, and checks every
// result in order while both sides idle and stall in random bursts
// ----------------------------------------------------------------------------
module testbench;
	import glla_pkg::*;

	localparam int NPROC = DEF_NUM_PROCESSORS;
	localparam int BLOCK_CAP = DEF_MAX_BLOCKS;
	localparam int COUNT_CAP = (DEF_MAX_BLOCKS < COUNT_MAX) ? DEF_MAX_BLOCKS : COUNT_MAX;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = NPROC + 6;

	typedef struct packed {
		logic [PROC_OUT_W-1:0] proc;
		logic [SLOT_W-1:0]     slot;
		logic                  empty;
		logic                  sat;
	} placement_t;

	class placement_board;
		logic [LOAD_W-1:0]  proc_load [NPROC];
		logic [COUNT_W-1:0] proc_count [NPROC];
		logic [CFG_W-1:0]   active_cfg = 1;
		placement_t         placements_due [$];
		int                 checked = 0;
		int                 errors = 0;

		function void clear_loads();
			foreach (proc_load[p]) begin
				proc_load[p] = '0;
				proc_count[p] = '0;
			end
		endfunction

		function void note_block(logic [EXT_W-1:0] ei, logic [EXT_W-1:0] ej,
				logic [EXT_W-1:0] ek, logic first, logic last);
			int n;
			int best;
			int p;
			logic [LOAD_W-1:0] work;
			logic [LOAD_W:0] total;
			placement_t want;
			if (first)
				clear_loads();
			n = active_cfg;
			if (n == 0)
				n = 1;
			if (n > NPROC)
				n = NPROC;
			best = 0;
			for (p = 1; p < n; p++)
				if (proc_load[p] < proc_load[best])
					best = p;
			want.proc = PROC_OUT_W'(best);
			want.slot = (proc_count[best] > BLOCK_CAP - 1) ? SLOT_W'(BLOCK_CAP - 1)
				: SLOT_W'(proc_count[best]);
			if (proc_count[best] < COUNT_CAP)
				proc_count[best] = proc_count[best] + 1'b1;
			work = LOAD_W'(ei) * LOAD_W'(ej) * LOAD_W'(ek);
			total = {1'b0, proc_load[best]} + {1'b0, work};
			proc_load[best] = (total > {1'b0, LOAD_MAX}) ? LOAD_MAX : total[LOAD_W-1:0];
			want.empty = 1'b0;
			if (last)
				for (p = 0; p < n; p++)
					if (proc_count[p] == 0)
						want.empty = 1'b1;
			want.sat = (proc_load[best] == LOAD_MAX);
			placements_due = {placements_due, want};
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_placement(placement_t got);
			placement_t want;
			if (placements_due.size() == 0) begin
				$display("%0t unexpected result: processor %0d slot %0d", $time,
					got.proc, got.slot);
				errors++;
			end else begin
				want = placements_due.pop_front();
				checked++;
				compare_field("assigned_processor", want.proc, got.proc);
				compare_field("slot_in_processor", want.slot, got.slot);
				compare_field("empty_processor_flag", want.empty, got.empty);
				compare_field("load_saturated", want.sat, got.sat);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [EXT_W-1:0] extent_i = '0;
	logic [EXT_W-1:0] extent_j = '0;
	logic [EXT_W-1:0] extent_k = '0;
	logic first_block = 1'b0;
	logic last_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PROC_OUT_W-1:0] assigned_processor;
	logic [SLOT_W-1:0] slot_in_processor;
	logic empty_processor_flag;
	logic load_saturated;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	placement_board board;
	bit quiet = 1'b0;
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int blocks_sent = 0;

	greedy_least_loaded_assigner_unit u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.extent_i             (extent_i),
		.extent_j             (extent_j),
		.extent_k             (extent_k),
		.first_block          (first_block),
		.last_block           (last_block),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.assigned_processor   (assigned_processor),
		.slot_in_processor    (slot_in_processor),
		.empty_processor_flag (empty_processor_flag),
		.load_saturated       (load_saturated),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_placement({assigned_processor, slot_in_processor,
				empty_processor_flag, load_saturated});
	end

	always @(posedge clk) begin
		if (!quiet && $urandom_range(0, 199) == 0)
			receiver_calm = !receiver_calm;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && !receiver_calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [EXT_W-1:0] pick_extent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return EXT_W'($urandom_range(0, 15));
			default: return EXT_W'($urandom);
		endcase
	endfunction

	function automatic int sender_gap();
		if (quiet || sender_calm || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 7);
	endfunction

	task automatic push_block(input logic [EXT_W-1:0] ei, input logic [EXT_W-1:0] ej,
			input logic [EXT_W-1:0] ek, input logic first, input logic last);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		extent_i <= ei;
		extent_j <= ej;
		extent_k <= ek;
		first_block <= first;
		last_block <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_block(ei, ej, ek, first, last);
		blocks_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.placements_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_active(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		board.active_cfg = value;
		cfg_we <= 1'b0;
	endtask

	task automatic random_stretch(input int items);
		int done;
		int len;
		int k;
		bit tidy;
		done = 0;
		while (done < items) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			tidy = ($urandom_range(0, 6) != 0);
			if (!tidy)
				len = $urandom_range(1, 5);
			else if ($urandom_range(0, 7) == 0)
				len = $urandom_range(25, 80);
			else
				len = $urandom_range(1, 24);
			for (k = 0; k < len; k++)
				push_block(pick_extent(), pick_extent(), pick_extent(),
					tidy ? (k == 0) : 1'($urandom_range(0, 1)),
					tidy ? (k == len - 1) : 1'($urandom_range(0, 1)));
			done += len;
		end
		sender_calm = 1'b0;
	endtask

	initial begin
		board = new;
		board.clear_loads();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state and reset register value
		push_block(5, 5, 5, 0, 1);

		set_active(4);
		push_block(0, 0, 0, 1, 0);
		push_block(0, 0, 0, 0, 0);
		push_block('1, '1, '1, 0, 0);
		push_block(1, 1, 1, 0, 0);
		push_block('1, 1, 1, 0, 1);
		push_block(1, '1, 1, 0, 0);
		push_block(1, 1, '1, 0, 1);

		// zero processors behaves as one
		set_active(0);
		push_block(7, 7, 7, 1, 1);
		push_block(0, 0, 0, 0, 1);

		// above the processor count clamps to all processors
		set_active(31);
		push_block(2, 3, 5, 1, 1);
		push_block('1, '1, '1, 0, 0);

		// inactive processors keep their loads
		set_active(2);
		push_block(3, 3, 3, 0, 1);
		set_active(16);
		push_block(1, 1, 1, 0, 1);

		set_active(1);
		random_stretch(50);
		set_active(16);
		random_stretch(80);
		set_active(0);
		random_stretch(40);
		set_active(31);
		random_stretch(60);
		set_active(CFG_W'($urandom_range(2, 15)));
		random_stretch(80);
		set_active(CFG_W'($urandom_range(17, 30)));
		random_stretch(40);
		set_active(CFG_W'($urandom_range(2, 15)));
		random_stretch(60);

		// one processor filled past the slot and block count caps
		set_active(1);
		quiet = 1'b1;
		push_block('1, '1, '1, 1, 0);
		repeat (1100)
			push_block(EXT_W'($urandom_range(3968, 4095)), EXT_W'($urandom_range(3968, 4095)),
				EXT_W'($urandom_range(3968, 4095)), 0, 1'($urandom_range(0, 15) == 0));
		drain_results();

		$display("run sent %0d blocks and checked %0d placements across active settings 0 to 31,",
			blocks_sent, board.checked);
		$display("including ties, zero extents, empty processor reports and the slot cap");
		if (board.errors == 0 && board.placements_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
